// ===== hw/rtl/rpwfd_pkg.sv =====
// shared types and constants for the card frame pulse-width decoder
// used by every module under hw/rtl; depends on nothing

package rpwfd_pkg;

	// configuration register reset values
	localparam logic [7:0] SHORT_MIN_RST = 8'd44;
	localparam logic [7:0] SHORT_MAX_RST = 8'd81;
	localparam logic [7:0] LONG_MIN_RST  = 8'd106;
	localparam logic [7:0] LONG_MAX_RST  = 8'd145;

	// frame geometry
	localparam int HEADER_PULSES_DEF = 16;
	localparam int FRAME_BITS        = 54;
	localparam int BIT_CNT_W         = 6;
	localparam int DATA_BYTES        = 6;
	localparam int ROW_BITS          = 5;
	localparam int CARD_W            = 40;

	// stream word and apb widths
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 56;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	typedef enum logic [1:0] {
		REG_SHORT_MIN = 2'd0,
		REG_SHORT_MAX = 2'd1,
		REG_LONG_MIN  = 2'd2,
		REG_LONG_MAX  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_SYNC   = 2'd0,
		PH_HEADER = 2'd1,
		PH_DATA   = 2'd2,
		PH_HELD   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] short_min;
		logic [7:0] short_max;
		logic [7:0] long_min;
		logic [7:0] long_max;
	} cfg_t;

	typedef struct packed {
		logic              frame_ready;
		logic [CARD_W-1:0] card_data;
		logic [3:0]        column_parity;
		phase_t            phase;
		logic              parity_error;
		logic              width_error;
	} result_t;

endpackage

// ===== hw/rtl/rfid_pulse_width_frame_decoder.sv =====
// top level of the card frame pulse-width decoder: input register, decode step,
// result buffer and apb bound registers; depends on rpwfd_pkg and all rpwfd_* modules
//
//   channel   direction  word
//   s_*       in         pulse event or acknowledge (tuser = func)
//   m_*       out        one decode result per input word
//   apb       in/out     short_min, short_max, long_min, long_max at 0x0/0x4/0x8/0xc
//
// one word per clock sustained while m_tready stays high; a result word is offered once its
// input word has passed the input register, the skid entry when the m side is stalled, and
// the result register, being decoded by the single decode step on the way
// arst_n clears all decode state, the bounds to their defaults, and empties both stages
// a stalled m side fills the skid entry first; s_tready drops only once it is full

module rfid_pulse_width_frame_decoder #(
	parameter int HEADER_PULSES = rpwfd_pkg::HEADER_PULSES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// pulse_width [15:0], line_level [16], zero pad [23:17]
	input  logic [rpwfd_pkg::S_TDATA_W-1:0]     s_tdata,
	// func: 0 pulse event, 1 acknowledge
	input  logic                                s_tuser,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// frame_ready [0], card_data [40:1], column_parity [44:41], phase [46:45],
	// parity_error [47], width_error [48], zero pad [55:49]
	output logic [rpwfd_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rpwfd_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [rpwfd_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [rpwfd_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready
);

	rpwfd_pkg::cfg_t    cfg;
	rpwfd_pkg::result_t step_res, out_res;

	// input register stage
	logic        valid_s1;
	logic        func_s1;
	logic [15:0] width_s1;
	logic        level_s1;

	logic buf_space, adv, in_take;

	// a word in the input register advances whenever the skid entry is free
	assign adv      = valid_s1 & buf_space;
	assign s_tready = ~valid_s1 | buf_space;
	assign in_take  = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_take)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1  <= s_tuser;
			width_s1 <= s_tdata[15:0];
			level_s1 <= s_tdata[16];
		end
	end

	rpwfd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// decode state moves one step per word leaving the input register
	rpwfd_core #(
		.HEADER_PULSES (HEADER_PULSES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.func        (func_s1),
		.pulse_width (width_s1),
		.line_level  (level_s1),
		.cfg         (cfg),
		.result      (step_res)
	);

	rpwfd_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv),
		.push_data (step_res),
		.space     (buf_space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	// pack the result word, first field in the low bits
	assign m_tdata = {7'd0,
	                  out_res.width_error,
	                  out_res.parity_error,
	                  out_res.phase,
	                  out_res.column_parity,
	                  out_res.card_data,
	                  out_res.frame_ready};

endmodule

// ===== hw/rtl/rpwfd_apb_regs.sv =====
// apb register file holding the four pulse width bounds
// depends on rpwfd_pkg

module rpwfd_apb_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rpwfd_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [rpwfd_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [rpwfd_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready,
	output rpwfd_pkg::cfg_t                     cfg
);

	rpwfd_pkg::cfg_t      cfg_q;
	rpwfd_pkg::reg_idx_t  idx;
	logic                 wr_en;
	logic [7:0]           rd_byte;

	assign pready = 1'b1;
	assign idx    = rpwfd_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_min <= rpwfd_pkg::SHORT_MIN_RST;
			cfg_q.short_max <= rpwfd_pkg::SHORT_MAX_RST;
			cfg_q.long_min  <= rpwfd_pkg::LONG_MIN_RST;
			cfg_q.long_max  <= rpwfd_pkg::LONG_MAX_RST;
		end else if (wr_en) begin
			unique case (idx)
				rpwfd_pkg::REG_SHORT_MIN: cfg_q.short_min <= pwdata[7:0];
				rpwfd_pkg::REG_SHORT_MAX: cfg_q.short_max <= pwdata[7:0];
				rpwfd_pkg::REG_LONG_MIN:  cfg_q.long_min  <= pwdata[7:0];
				rpwfd_pkg::REG_LONG_MAX:  cfg_q.long_max  <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			rpwfd_pkg::REG_SHORT_MIN: rd_byte = cfg_q.short_min;
			rpwfd_pkg::REG_SHORT_MAX: rd_byte = cfg_q.short_max;
			rpwfd_pkg::REG_LONG_MIN:  rd_byte = cfg_q.long_min;
			rpwfd_pkg::REG_LONG_MAX:  rd_byte = cfg_q.long_max;
		endcase
	end

	assign prdata = {{(rpwfd_pkg::APB_DATA_W-8){1'b0}}, rd_byte};
	assign cfg    = cfg_q;

endmodule

// ===== hw/rtl/rpwfd_core.sv =====
// decoder state and single-step next-state logic for one pulse or ack word
// depends on rpwfd_pkg

module rpwfd_core #(
	parameter int HEADER_PULSES = rpwfd_pkg::HEADER_PULSES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                func,
	input  logic [15:0]         pulse_width,
	input  logic                line_level,
	input  rpwfd_pkg::cfg_t     cfg,
	output rpwfd_pkg::result_t  result
);

	localparam int HDR_W = $clog2(HEADER_PULSES + 1);
	localparam int NB    = rpwfd_pkg::DATA_BYTES;
	localparam int BCW   = rpwfd_pkg::BIT_CNT_W;

	typedef logic [NB-1:0][7:0] bytes_t;

	rpwfd_pkg::phase_t phase_q, phase_n;
	logic [HDR_W-1:0]  hdr_q, hdr_n, hdr_inc;
	logic              half_q, half_n;
	bytes_t            bytes_q, bytes_n;
	logic [BCW-1:0]    bits_q, bits_n, bits_inc;
	logic [2:0]        rowpos_q, rowpos_n, rowpos_inc;
	logic              tog_q, tog_n;
	logic [2:0]        bidx_q, bidx_n;
	logic [2:0]        ones_q, ones_n, ones_inc;
	logic              pend_q, pend_n;

	logic       is_short, is_long, low, take, idx_ok, perr, werr;
	logic [7:0] cur_byte;

	assign low        = ~line_level;
	assign is_short   = (pulse_width > {8'd0, cfg.short_min}) &&
	                    (pulse_width < {8'd0, cfg.short_max});
	assign is_long    = (pulse_width > {8'd0, cfg.long_min}) &&
	                    (pulse_width < {8'd0, cfg.long_max});
	assign hdr_inc    = hdr_q + HDR_W'(1);
	assign bits_inc   = bits_q + BCW'(1);
	assign rowpos_inc = rowpos_q + 3'd1;
	assign ones_inc   = low ? ones_q + 3'd1 : ones_q;
	assign idx_ok     = bidx_q < 3'(NB);

	always_comb begin
		phase_n  = phase_q;
		hdr_n    = hdr_q;
		half_n   = half_q;
		bytes_n  = bytes_q;
		bits_n   = bits_q;
		rowpos_n = rowpos_q;
		tog_n    = tog_q;
		bidx_n   = bidx_q;
		ones_n   = ones_q;
		pend_n   = pend_q;
		perr     = 1'b0;
		werr     = 1'b0;
		take     = 1'b0;
		cur_byte = 8'd0;

		if (func) begin
			pend_n = 1'b0;
		end else begin
			unique case (phase_q)
				rpwfd_pkg::PH_SYNC: begin
					if (low && (pulse_width > {8'd0, cfg.long_min})) begin
						hdr_n   = '0;
						phase_n = rpwfd_pkg::PH_HEADER;
					end
				end
				rpwfd_pkg::PH_HEADER: begin
					if (!is_short) begin
						phase_n = rpwfd_pkg::PH_SYNC;
						werr    = 1'b1;
					end else begin
						hdr_n = hdr_inc;
						if (hdr_inc == HDR_W'(HEADER_PULSES)) begin
							phase_n  = rpwfd_pkg::PH_DATA;
							bidx_n   = 3'd0;
							rowpos_n = 3'd0;
							ones_n   = 3'd0;
							tog_n    = 1'b0;
							half_n   = 1'b0;
							bits_n   = '0;
						end
					end
				end
				rpwfd_pkg::PH_DATA: begin
					if (is_short) begin
						half_n = ~half_q;
						take   = half_q;
					end else if (is_long) begin
						take = 1'b1;
					end else begin
						phase_n = rpwfd_pkg::PH_SYNC;
						werr    = 1'b1;
					end
				end
				rpwfd_pkg::PH_HELD: begin
					// first pulse after the ack drops the frame
					if (!pend_q) begin
						bytes_n = '0;
						phase_n = rpwfd_pkg::PH_SYNC;
					end
				end
			endcase
		end

		if (take) begin
			// shift into the current byte; the row parity bit is not stored
			for (int i = 0; i < NB; i++) begin
				if (idx_ok && (bidx_q == 3'(i))) begin
					cur_byte = bytes_q[i];
					if (rowpos_q != 3'd4)
						cur_byte = {cur_byte[6:0], 1'b0};
					if (low && (rowpos_inc != 3'(rpwfd_pkg::ROW_BITS)))
						cur_byte[0] = 1'b1;
					bytes_n[i] = cur_byte;
				end
			end
			half_n   = 1'b0;
			bits_n   = bits_inc;
			rowpos_n = rowpos_inc;
			ones_n   = ones_inc;
			if (rowpos_inc == 3'(rpwfd_pkg::ROW_BITS)) begin
				if (ones_inc[0]) begin
					phase_n = rpwfd_pkg::PH_SYNC;
					perr    = 1'b1;
				end
				rowpos_n = 3'd0;
				tog_n    = ~tog_q;
				if (tog_q)
					bidx_n = bidx_q + 3'd1;
				ones_n = 3'd0;
			end
			if (bits_inc >= BCW'(rpwfd_pkg::FRAME_BITS)) begin
				pend_n  = 1'b1;
				phase_n = rpwfd_pkg::PH_HELD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rpwfd_pkg::PH_SYNC;
			hdr_q    <= '0;
			half_q   <= 1'b0;
			bytes_q  <= '0;
			bits_q   <= '0;
			rowpos_q <= 3'd0;
			tog_q    <= 1'b0;
			bidx_q   <= 3'd0;
			ones_q   <= 3'd0;
			pend_q   <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			hdr_q    <= hdr_n;
			half_q   <= half_n;
			bytes_q  <= bytes_n;
			bits_q   <= bits_n;
			rowpos_q <= rowpos_n;
			tog_q    <= tog_n;
			bidx_q   <= bidx_n;
			ones_q   <= ones_n;
			pend_q   <= pend_n;
		end
	end

	always_comb begin
		result.frame_ready   = pend_n;
		result.phase         = phase_n;
		result.parity_error  = perr;
		result.width_error   = werr;
		result.card_data     = '0;
		result.column_parity = 4'd0;
		if (phase_n == rpwfd_pkg::PH_HELD) begin
			result.card_data     = {bytes_n[0], bytes_n[1], bytes_n[2], bytes_n[3], bytes_n[4]};
			result.column_parity = bytes_n[5][3:0];
		end
	end

endmodule

// ===== hw/rtl/rpwfd_out_buf.sv =====
// result register with a skid entry behind it
// depends on rpwfd_pkg

module rpwfd_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rpwfd_pkg::result_t  push_data,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output rpwfd_pkg::result_t  out_data
);

	logic               out_v_q, skid_v_q;
	rpwfd_pkg::result_t out_d_q, skid_d_q;
	logic               pop;

	assign pop       = out_v_q & out_ready;
	assign space     = ~skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || pop) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= push;
				end
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			if (skid_v_q)
				out_d_q <= skid_d_q;
			else if (push)
				out_d_q <= push_data;
		end else if (push) begin
			skid_d_q <= push_data;
		end
	end

endmodule
